FILE: rtl/core/grid_cell_occupancy_counter_assert.svh
// Assertion macros shared by the occupancy counter modules.
// No dependencies.
`ifndef GRID_CELL_OCCUPANCY_COUNTER_ASSERT_SVH
`define GRID_CELL_OCCUPANCY_COUNTER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define GCOC_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define GCOC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

FILE: rtl/core/gcoc_pkg.sv
// Package for the grid cell occupancy counter: constants, opcodes and types.
// No dependencies.
package gcoc_pkg;
   localparam int TableEntries = 64;
   localparam int IdxW = $clog2(TableEntries);
   localparam int CntW = IdxW + 1;
   localparam logic [15:0] CountMax = 16'hFFFF;
   localparam logic [23:0] GridPitchReset = 24'd2560;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_REMOVE = 2'd1,
      OP_MOVE = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   typedef struct packed {
      op_type op;
      logic [63:0] key_old;
      logic [63:0] key_new;
   } cmd_type;
endpackage

FILE: rtl/core/gcoc_div.sv
// Serial floor divider of a signed 32-bit coordinate by the cell size.
// No dependencies.
module gcoc_div (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [31:0] dividend,
   input  logic [23:0] divisor,
   output logic busy,
   output logic done,
   output logic [31:0] quotient
);
   logic [5:0] step_ff, step_in;
   logic busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic [31:0] q_ff, q_in;
   logic [24:0] rem_ff, rem_in;
   logic [23:0] div_ff, div_in;
   logic [24:0] trial;
   logic [31:0] mag;
   logic [31:0] qfin;

   always_comb begin
      mag = dividend[31] ? (~dividend + 32'd1) : dividend;
      trial = {rem_ff[23:0], q_ff[31]};
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in = neg_ff;
      q_in = q_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      qfin = 32'd0;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         step_in = 6'd0;
         neg_in = dividend[31];
         q_in = mag;
         rem_in = 25'd0;
         div_in = (divisor == 24'd0) ? 24'd1 : divisor;
      end else if (busy_ff) begin
         q_in = {q_ff[30:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
            q_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         step_in = step_ff + 6'd1;
         if (step_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      if (!neg_ff) begin
         qfin = q_ff;
      end else if (rem_ff != 25'd0) begin
         qfin = ~q_ff;
      end else begin
         qfin = ~q_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      neg_ff <= neg_in;
      q_ff <= q_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quotient = qfin;
endmodule

FILE: rtl/core/gcoc_front.sv
// Front end: accepts words, maps positions to cell keys with four dividers.
// Depends on gcoc_pkg and gcoc_div.
`include "grid_cell_occupancy_counter_assert.svh"
module gcoc_front (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic [1:0] req_opcode,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_new_x,
   input  logic signed [31:0] req_new_y,
   input  logic [23:0] grid_pitch,
   output logic cmd_valid,
   input  logic cmd_ready,
   output gcoc_pkg::cmd_type cmd
);
   logic busy_ff, busy_in, hold_ff, hold_in;
   gcoc_pkg::op_type op_ff, op_in;
   logic [3:0] busy_d, done_d;
   logic [31:0] q0, q1, q2, q3;
   logic start;

   assign start = req_push && !req_full;
   assign req_full = busy_ff || hold_ff;

   gcoc_div u_div0 (.clock, .reset, .start, .dividend(req_pos_x), .divisor(grid_pitch),
      .busy(busy_d[0]), .done(done_d[0]), .quotient(q0));
   gcoc_div u_div1 (.clock, .reset, .start, .dividend(req_pos_y), .divisor(grid_pitch),
      .busy(busy_d[1]), .done(done_d[1]), .quotient(q1));
   gcoc_div u_div2 (.clock, .reset, .start, .dividend(req_new_x), .divisor(grid_pitch),
      .busy(busy_d[2]), .done(done_d[2]), .quotient(q2));
   gcoc_div u_div3 (.clock, .reset, .start, .dividend(req_new_y), .divisor(grid_pitch),
      .busy(busy_d[3]), .done(done_d[3]), .quotient(q3));

   always_comb begin
      busy_in = busy_ff;
      hold_in = hold_ff;
      op_in = op_ff;
      if (start) begin
         busy_in = 1'b1;
         op_in = gcoc_pkg::op_type'(req_opcode);
      end
      if (done_d[0]) begin
         busy_in = 1'b0;
         hold_in = 1'b1;
      end
      if (hold_ff && cmd_ready) begin
         hold_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         hold_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         hold_ff <= hold_in;
      end
      op_ff <= op_in;
   end

   assign cmd_valid = hold_ff;
   assign cmd.op = op_ff;
   assign cmd.key_old = {q0, q1};
   assign cmd.key_new = {q2, q3};

   `GCOC_ASSERT_IMP(a_div_lockstep, clock, reset, 1'b1, (busy_d == 4'h0) || (busy_d == 4'hF))
   `GCOC_ASSERT_IMP(a_no_overlap, clock, reset, busy_ff, !hold_ff)
   `GCOC_ASSERT_NEXT(a_start_busy, clock, reset, start, busy_d[0])
   `GCOC_ASSERT_IMP(a_done_sync, clock, reset, 1'b1, done_d == {4{done_d[0]}})
endmodule

FILE: rtl/core/gcoc_fifo.sv
// Two-entry queue of classified commands between front and back ends.
// Depends on gcoc_pkg.
module gcoc_fifo (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  gcoc_pkg::cmd_type in_cmd,
   output logic out_valid,
   input  logic out_ready,
   output gcoc_pkg::cmd_type out_cmd
);
   gcoc_pkg::cmd_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic wr, rd;

   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;
   assign out_cmd = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
      if (wr) mem_ff[wp_ff] <= in_cmd;
   end
endmodule

FILE: rtl/core/gcoc_back.sv
// Back end: searches the cell table entry by entry and updates counts.
// Depends on gcoc_pkg.
`include "grid_cell_occupancy_counter_assert.svh"
module gcoc_back (
   input  logic clock,
   input  logic reset,
   input  logic cmd_valid,
   output logic cmd_ready,
   input  gcoc_pkg::cmd_type cmd,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [15:0] rsp_density,
   output logic rsp_status
);
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SCAN = 6'b000010,
      ST_UPD = 6'b000100,
      ST_NEXT = 6'b001000,
      ST_DONE = 6'b010000,
      ST_OUT = 6'b100000
   } state_type;

   localparam int IW = gcoc_pkg::IdxW;
   localparam int CW = gcoc_pkg::CntW;
   localparam int N = gcoc_pkg::TableEntries;

   state_type st_ff, st_in;
   logic [N-1:0] valid_ff, valid_in;
   logic [63:0] key_ff [N];
   logic [15:0] count_ff [N];
   logic [63:0] key_rd_ff;
   logic [15:0] cnt_rd_ff;
   logic [15:0] hcnt_ff, hcnt_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [CW-1:0] pscan;
   logic [IW-1:0] hit_ff, hit_in, free_ff, free_in;
   logic found_ff, found_in, hasfree_ff, hasfree_in;
   logic phase_ff, phase_in; // 0 first access, 1 add of a move
   logic isadd_ff, isadd_in;
   gcoc_pkg::cmd_type c_ff, c_in;
   logic [15:0] dens_ff, dens_in;
   logic stat_ff, stat_in;
   logic [63:0] cur_key;
   logic [IW-1:0] si;
   logic [IW-1:0] pi;
   logic wr_en;
   logic [IW-1:0] wr_idx;
   logic [63:0] wr_key;
   logic [15:0] wr_cnt;
   logic wr_valid;
   logic [15:0] hc;

   // The table is read one entry a cycle with registered data, so each entry
   // is compared in the cycle after its address is presented.
   assign cur_key = phase_ff ? c_ff.key_new : c_ff.key_old;
   assign si = scan_ff[IW-1:0];
   assign pscan = scan_ff - CW'(1);
   assign pi = pscan[IW-1:0];
   assign hc = hcnt_ff;

   always_comb begin
      st_in = st_ff;
      scan_in = scan_ff;
      hit_in = hit_ff;
      hcnt_in = hcnt_ff;
      free_in = free_ff;
      found_in = found_ff;
      hasfree_in = hasfree_ff;
      phase_in = phase_ff;
      isadd_in = isadd_ff;
      c_in = c_ff;
      dens_in = dens_ff;
      stat_in = stat_ff;
      valid_in = valid_ff;
      wr_en = 1'b0;
      wr_idx = hit_ff;
      wr_key = cur_key;
      wr_cnt = 16'd0;
      wr_valid = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               c_in = cmd;
               phase_in = 1'b0;
               stat_in = 1'b0;
               dens_in = 16'd0;
               if (cmd.op == gcoc_pkg::OP_MOVE && cmd.key_old == cmd.key_new) begin
                  isadd_in = 1'b0;
                  c_in.op = gcoc_pkg::OP_QUERY;
               end else begin
                  isadd_in = cmd.op == gcoc_pkg::OP_ADD;
               end
               scan_in = '0;
               found_in = 1'b0;
               hasfree_in = 1'b0;
               st_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ff != '0 && valid_ff[pi] && key_rd_ff == cur_key && !found_ff) begin
               found_in = 1'b1;
               hit_in = pi;
               hcnt_in = cnt_rd_ff;
            end
            if (scan_ff != CW'(N) && !valid_ff[si] && !hasfree_ff) begin
               hasfree_in = 1'b1;
               free_in = si;
            end
            scan_in = scan_ff + CW'(1);
            if (scan_ff == CW'(N)) st_in = ST_UPD;
         end
         ST_UPD: begin
            st_in = ST_NEXT;
            if (isadd_ff) begin
               if (found_ff) begin
                  wr_en = 1'b1;
                  wr_cnt = (hc == gcoc_pkg::CountMax) ? hc : hc + 16'd1;
                  wr_valid = 1'b1;
                  dens_in = wr_cnt;
               end else if (hasfree_ff) begin
                  wr_en = 1'b1;
                  wr_idx = free_ff;
                  wr_cnt = 16'd1;
                  wr_valid = 1'b1;
                  dens_in = 16'd1;
               end else begin
                  dens_in = 16'd0;
                  stat_in = 1'b1;
               end
            end else if (c_ff.op == gcoc_pkg::OP_QUERY) begin
               dens_in = found_ff ? hc : 16'd0;
            end else begin
               dens_in = 16'd0;
               if (found_ff) begin
                  wr_en = 1'b1;
                  wr_cnt = hc - 16'd1;
                  wr_valid = hc > 16'd1;
                  dens_in = wr_valid ? wr_cnt : 16'd0;
               end
            end
         end
         ST_NEXT: begin
            if (c_ff.op == gcoc_pkg::OP_MOVE && !phase_ff) begin
               phase_in = 1'b1;
               isadd_in = 1'b1;
               scan_in = '0;
               found_in = 1'b0;
               hasfree_in = 1'b0;
               st_in = ST_SCAN;
            end else begin
               st_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_pop) st_in = ST_DONE;
         end
         ST_DONE: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
      if (wr_en) valid_in[wr_idx] = wr_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         valid_ff <= '0;
      end else begin
         st_ff <= st_in;
         valid_ff <= valid_in;
      end
      if (wr_en) begin
         key_ff[wr_idx] <= wr_key;
         count_ff[wr_idx] <= wr_cnt;
      end
      key_rd_ff <= key_ff[si];
      cnt_rd_ff <= count_ff[si];
      hcnt_ff <= hcnt_in;
      scan_ff <= scan_in;
      hit_ff <= hit_in;
      free_ff <= free_in;
      found_ff <= found_in;
      hasfree_ff <= hasfree_in;
      phase_ff <= phase_in;
      isadd_ff <= isadd_in;
      c_ff <= c_in;
      dens_ff <= dens_in;
      stat_ff <= stat_in;
   end

   assign cmd_ready = st_ff == ST_IDLE;
   assign rsp_empty = st_ff != ST_OUT;
   assign rsp_density = dens_ff;
   assign rsp_status = stat_ff;

   `GCOC_ASSERT_IMP(a_state_onehot, clock, reset, 1'b1, $onehot(st_ff))
   `GCOC_ASSERT_IMP(a_status_zero, clock, reset, !rsp_empty && rsp_status, rsp_density == 16'd0)
   `GCOC_ASSERT_NEXT(a_pop_leaves, clock, reset, !rsp_empty && rsp_pop, rsp_empty)
endmodule

FILE: rtl/core/grid_cell_occupancy_counter.sv
// Top level of the grid cell occupancy counter.
// Depends on gcoc_pkg, gcoc_front, gcoc_fifo and gcoc_back.
// In the front end each word passes through the accept, 32 steps of the four
// serial floor dividers running in step, the done strobe and the hand-over to
// the queue. The back end then makes a table pass (a scan of all 64 entries
// through the registered table read, the update and a step state), two passes
// for a move, plus taking the command, the result hand-over and the return to
// idle; the back-end scan sets the sustained rate.
module grid_cell_occupancy_counter (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic [1:0] req_opcode,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_new_x,
   input  logic signed [31:0] req_new_y,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [15:0] rsp_density,
   output logic rsp_status,
   input  logic csr_we,
   input  logic [23:0] csr_grid_pitch
);
   logic [23:0] grid_pitch_ff;
   logic f_valid, f_ready, b_valid, b_ready;
   gcoc_pkg::cmd_type f_cmd, b_cmd;

   always_ff @(posedge clock) begin
      if (reset) grid_pitch_ff <= gcoc_pkg::GridPitchReset;
      else if (csr_we) grid_pitch_ff <= csr_grid_pitch;
   end

   gcoc_front u_front (.clock, .reset, .req_push, .req_full, .req_opcode,
      .req_pos_x, .req_pos_y, .req_new_x, .req_new_y, .grid_pitch(grid_pitch_ff),
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd));
   gcoc_fifo u_fifo (.clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
      .out_valid(b_valid), .out_ready(b_ready), .out_cmd(b_cmd));
   gcoc_back u_back (.clock, .reset, .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
      .rsp_empty, .rsp_pop, .rsp_density, .rsp_status);
endmodule
